// ===== rtl/brf_pkg.sv =====
package brf_pkg;

    localparam logic [2:0] OP_WR_START = 3'd0;
    localparam logic [2:0] OP_WR_BYTE  = 3'd1;
    localparam logic [2:0] OP_READ     = 3'd2;
    localparam logic [2:0] OP_PEEK     = 3'd3;
    localparam logic [2:0] OP_FLUSH    = 3'd4;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_REJECT = 2'd1;
    localparam logic [1:0] ST_DROP   = 2'd2;

    // commands from the controller to the datapath
    typedef struct packed {
        logic resv;     // write start
        logic put;      // write byte
        logic clear;    // flush
        logic empty;    // read or peek that finds nothing
        logic load;     // read or peek with bytes to emit
        logic step;     // emit one byte of a burst
        logic consume;  // burst is a read, not a peek
    } t_cmd;

    typedef struct packed {
        logic none_avail;  // burst length works out to zero
        logic final_step;  // the step under way emits the last byte
    } t_stat;

endpackage

// ===== rtl/brf_ctrl.sv =====
module brf_ctrl
    import brf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [2:0]  i_opcode,
    input  t_stat       i_stat,
    output logic        o_busy,
    output t_cmd        o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_BURST
    } t_state;

    t_state r_state;
    logic   r_is_read;
    logic   accept;
    logic   burst_op;

    assign accept   = i_start && (r_state == S_IDLE);
    assign burst_op = (i_opcode == OP_READ) || (i_opcode == OP_PEEK);

    always_comb begin
        o_cmd.resv    = accept && (i_opcode == OP_WR_START);
        o_cmd.put     = accept && (i_opcode == OP_WR_BYTE);
        o_cmd.clear   = accept && (i_opcode == OP_FLUSH);
        o_cmd.empty   = accept && burst_op && i_stat.none_avail;
        o_cmd.load    = accept && burst_op && !i_stat.none_avail;
        o_cmd.step    = (r_state == S_BURST);
        o_cmd.consume = r_is_read;
    end

    assign o_busy = (r_state == S_BURST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_is_read <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (o_cmd.load) begin
                        r_state   <= S_BURST;
                        r_is_read <= (i_opcode == OP_READ);
                    end
                end
                S_BURST: begin
                    if (i_stat.final_step) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/brf_datapath.sv =====
module brf_datapath
    import brf_pkg::*;
#(
    parameter int DEPTH     = 256,
    parameter int MAX_BURST = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  logic [8:0]  i_count,
    input  logic [7:0]  i_data_byte,
    input  logic        i_cfg_we,
    input  logic [8:0]  i_cfg_data,
    output logic        o_valid,
    output logic [7:0]  o_out_byte,
    output logic        o_byte_valid,
    output logic        o_last,
    output logic [1:0]  o_status,
    output logic [8:0]  o_used_count,
    output logic [15:0] o_overrun_count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW = (AW > 9) ? AW : 9;
    localparam int BW = $clog2(MAX_BURST + 1);
    localparam logic [8:0] SIZE_MAX   = (DEPTH > 511) ? 9'd511 : 9'(DEPTH);
    localparam logic [8:0] RESET_SIZE = (DEPTH < 256) ? 9'(DEPTH) : 9'd256;
    localparam logic [8:0] BURST_CAP  = 9'(MAX_BURST);

    logic [7:0]    r_store [DEPTH];
    logic [7:0]    r_rdata;

    logic [8:0]    r_size,    n_size;
    logic [PW-1:0] r_head,    n_head;
    logic [PW-1:0] r_tail,    n_tail;
    logic [PW-1:0] r_pos,     n_pos;
    logic [8:0]    r_free,    n_free;
    logic [8:0]    r_pending, n_pending;
    logic [8:0]    r_used,    n_used;
    logic [15:0]   r_overrun, n_overrun;
    logic [BW-1:0] r_remain,  n_remain;
    logic          r_strobe,  n_strobe;
    logic          r_bvalid,  n_bvalid;
    logic          r_last,    n_last;
    logic [1:0]    r_status,  n_status;

    logic          wr_en;
    logic [8:0]    cfg_size;
    logic [8:0]    lim_used;
    logic [8:0]    lim;
    logic [PW-1:0] head_adv;
    logic [PW-1:0] pos_adv;

    function automatic logic [PW-1:0] advance(input logic [PW-1:0] idx,
                                              input logic [8:0]    size);
        logic [PW:0] nx;
        nx = {1'b0, idx} + (PW+1)'(1);
        if (nx >= {{(PW-8){1'b0}}, size}) begin
            nx = '0;
        end
        return nx[PW-1:0];
    endfunction

    // store size clamped to between one and what the memory holds
    always_comb begin
        if (i_cfg_data == 9'd0) begin
            cfg_size = 9'd1;
        end else if (32'(i_cfg_data) > DEPTH) begin
            cfg_size = SIZE_MAX;
        end else begin
            cfg_size = i_cfg_data;
        end
    end

    assign lim_used = (i_count < r_used) ? i_count : r_used;
    assign lim      = (lim_used > BURST_CAP) ? BURST_CAP : lim_used;
    assign head_adv = advance(r_head, r_size);
    assign pos_adv  = advance(r_pos, r_size);

    assign o_stat.none_avail = (lim == 9'd0);
    assign o_stat.final_step = (r_remain == BW'(1));

    always_comb begin
        n_size    = r_size;
        n_head    = r_head;
        n_tail    = r_tail;
        n_pos     = r_pos;
        n_free    = r_free;
        n_pending = r_pending;
        n_used    = r_used;
        n_overrun = r_overrun;
        n_remain  = r_remain;
        n_strobe  = 1'b0;
        n_bvalid  = 1'b0;
        n_last    = 1'b1;
        n_status  = ST_OK;
        wr_en     = 1'b0;
        if (i_cfg_we) begin
            n_size    = cfg_size;
            n_head    = '0;
            n_tail    = '0;
            n_free    = cfg_size;
            n_pending = '0;
            n_used    = '0;
            n_overrun = '0;
        end else if (i_cmd.resv) begin
            n_strobe = 1'b1;
            if (r_free < i_count) begin
                n_overrun = r_overrun + 16'd1;
                n_status  = ST_REJECT;
            end else begin
                n_free    = r_free - i_count;
                n_pending = r_pending + i_count;
            end
        end else if (i_cmd.put) begin
            n_strobe = 1'b1;
            if (r_pending == 9'd0) begin
                n_status = ST_DROP;
            end else begin
                wr_en     = 1'b1;
                n_head    = head_adv;
                n_pending = r_pending - 9'd1;
                n_used    = r_used + 9'd1;
            end
        end else if (i_cmd.clear) begin
            n_strobe  = 1'b1;
            n_head    = '0;
            n_tail    = '0;
            n_free    = r_size;
            n_pending = '0;
            n_used    = '0;
            n_overrun = '0;
        end else if (i_cmd.empty) begin
            n_strobe = 1'b1;
        end else if (i_cmd.load) begin
            n_pos    = r_tail;
            n_remain = lim[BW-1:0];
        end else if (i_cmd.step) begin
            n_strobe = 1'b1;
            n_bvalid = 1'b1;
            n_last   = o_stat.final_step;
            n_pos    = pos_adv;
            n_remain = r_remain - BW'(1);
            if (i_cmd.consume) begin
                n_tail = pos_adv;
                n_free = r_free + 9'd1;
                n_used = r_used - 9'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size    <= RESET_SIZE;
            r_head    <= '0;
            r_tail    <= '0;
            r_pos     <= '0;
            r_free    <= RESET_SIZE;
            r_pending <= '0;
            r_used    <= '0;
            r_overrun <= '0;
            r_remain  <= '0;
            r_strobe  <= 1'b0;
        end else begin
            r_size    <= n_size;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_pos     <= n_pos;
            r_free    <= n_free;
            r_pending <= n_pending;
            r_used    <= n_used;
            r_overrun <= n_overrun;
            r_remain  <= n_remain;
            r_strobe  <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bvalid <= n_bvalid;
        r_last   <= n_last;
        r_status <= n_status;
    end

    // byte store, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[r_head[AW-1:0]] <= i_data_byte;
        end
        if (i_cmd.step) begin
            r_rdata <= r_store[r_pos[AW-1:0]];
        end else begin
            r_rdata <= '0;
        end
    end

    assign o_valid         = r_strobe;
    assign o_out_byte      = r_rdata;
    assign o_byte_valid    = r_bvalid;
    assign o_last          = r_last;
    assign o_status        = r_status;
    assign o_used_count    = r_used;
    assign o_overrun_count = r_overrun;

endmodule

// ===== rtl/byte_ring_fifo_with_overrun_unit.sv =====
// Byte ring FIFO with write reservations and a 16-bit overrun counter. Results come out
// on o_valid for exactly one cycle and cannot be held off, so the receiver must take every
// one. Write start, write byte and flush may follow one another back to back, with the
// result in the cycle after the transfer. A read or peek of n bytes (n = min(count,
// stored, MAX_BURST), at least one result) holds o_busy high through the burst after a
// setup step, the single read port of the byte store giving one byte a cycle. Opcodes
// 5 to 7 give no result. Writing the size register empties the FIFO and clears the
// overrun counter; it is to be written only while idle.
module byte_ring_fifo_with_overrun_unit
    import brf_pkg::*;
#(
    parameter int DEPTH     = 256,
    parameter int MAX_BURST = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [2:0]  i_opcode,
    input  logic [8:0]  i_count,
    input  logic [7:0]  i_data_byte,
    input  logic        i_cfg_we,
    input  logic [8:0]  i_cfg_data,
    output logic        o_valid,
    output logic [7:0]  o_out_byte,
    output logic        o_byte_valid,
    output logic        o_last,
    output logic [1:0]  o_status,
    output logic [8:0]  o_used_count,
    output logic [15:0] o_overrun_count
);

    t_cmd  cmd;
    t_stat stat;

    brf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_opcode (i_opcode),
        .i_stat   (stat),
        .o_busy   (o_busy),
        .o_cmd    (cmd)
    );

    brf_datapath #(
        .DEPTH     (DEPTH),
        .MAX_BURST (MAX_BURST)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_count         (i_count),
        .i_data_byte     (i_data_byte),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .o_valid         (o_valid),
        .o_out_byte      (o_out_byte),
        .o_byte_valid    (o_byte_valid),
        .o_last          (o_last),
        .o_status        (o_status),
        .o_used_count    (o_used_count),
        .o_overrun_count (o_overrun_count)
    );

endmodule
